// ----- rtl/core/vfcm_pkg.sv -----
// Shared types and constants for the virtual FAT16 cluster mapper.
package vfcm_pkg;

  localparam int SIZE_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int TARGET_W = 24;
  localparam int CFG_W    = 7;
  localparam int INDEX_W  = 6;
  localparam int SECOFS_W = 23;
  localparam int FAT_W    = 16;

  // sector count of one file, rounded up to whole clusters, always below 2**24
  localparam int SEC_W   = 24;
  localparam int WORD_W  = FAT_W + SEC_W;
  localparam int SECTOR_SHIFT = 9;

  localparam logic [2:0] REQ_CLEAR    = 3'd0;
  localparam logic [2:0] REQ_ADD_FILE = 3'd1;
  localparam logic [2:0] REQ_ADD_META = 3'd2;
  localparam logic [2:0] REQ_READ_FAT = 3'd3;
  localparam logic [2:0] REQ_MAP_SEC  = 3'd4;

  localparam logic [FAT_W-1:0] FAT_ENTRY0  = 16'hFFF8;
  localparam logic [FAT_W-1:0] FAT_EOC     = 16'hFFFF;
  localparam logic [FAT_W-1:0] FIRST_CLUST = 16'd2;

  localparam logic [CFG_W-1:0] TABLE_ENTRIES_RST = 7'd64;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD_FILE,
    OP_ADD_META,
    OP_FAT,
    OP_MAP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SEC_W-1:0]    sectors;
    logic [COUNT_W-1:0]  slot_count;
    logic [TARGET_W-1:0] target;
  } cmd_t;

  typedef struct packed {
    logic                status;
    logic [FAT_W-1:0]    fat_entry;
    logic                hit;
    logic [INDEX_W-1:0]  file_index;
    logic [SECOFS_W-1:0] sector_in_file;
  } res_t;

endpackage

// ----- rtl/core/vfcm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vfcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/vfcm_front.sv -----
// Front end: accepts request transactions, classifies them and queues commands.
module vfcm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [2:0]                     req_type_i,
  input  logic [vfcm_pkg::SIZE_W-1:0]    file_size_i,
  input  logic [vfcm_pkg::COUNT_W-1:0]   slot_count_i,
  input  logic [vfcm_pkg::TARGET_W-1:0]  target_index_i,
  output logic                           cmd_valid_o,
  output vfcm_pkg::cmd_t                 cmd_o,
  input  logic                           cmd_take_i
);
  import vfcm_pkg::*;

  cmd_t       entry_q [2];
  cmd_t       cmd_new;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  always_comb begin
    cmd_new            = '0;
    cmd_new.slot_count = slot_count_i;
    cmd_new.target     = target_index_i;
    cmd_new.sectors    = {1'b0, file_size_i[SIZE_W-1:SECTOR_SHIFT]}
                         + SEC_W'(|file_size_i[SECTOR_SHIFT-1:0]);
    unique case (req_type_i)
      REQ_CLEAR:    cmd_new.op = OP_CLEAR;
      REQ_ADD_FILE: cmd_new.op = OP_ADD_FILE;
      REQ_ADD_META: cmd_new.op = OP_ADD_META;
      REQ_READ_FAT: cmd_new.op = OP_FAT;
      REQ_MAP_SEC:  cmd_new.op = OP_MAP;
      default:      cmd_new.op = OP_NOP;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rp_q];
  assign wr          = push_i & ~full_o;
  assign rd          = cmd_take_i & cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) begin
        wp_q <= ~wp_q;
      end
      if (rd) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      entry_q[wp_q] <= cmd_new;
    end
  end

endmodule

// ----- rtl/core/vfcm_back.sv -----
// Back end: slot table, cluster-count stage, table walk and result register.
module vfcm_back #(
  parameter int MAX_ENTRIES         = 64,
  parameter int SECTORS_PER_CLUSTER = 2,
  localparam int CntW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  vfcm_pkg::cmd_t             cmd_i,
  output logic                       cmd_take_o,
  input  logic [vfcm_pkg::CFG_W-1:0] table_entries_i,
  output logic                       res_valid_o,
  output vfcm_pkg::res_t             res_o,
  input  logic                       res_take_i,
  output logic                       busy_o,
  output logic [CntW-1:0]            used_o
);
  import vfcm_pkg::*;

  localparam int IdxW     = $clog2(MAX_ENTRIES);
  localparam int LimW     = (CntW > CFG_W) ? CntW : CFG_W;
  // exact floor division of a 24-bit count by the cluster size via reciprocal
  localparam int DivShift = SEC_W + $clog2(SECTORS_PER_CLUSTER);
  localparam int ProdW    = DivShift + SEC_W;
  localparam logic [SEC_W:0] RecipM = (SEC_W+1)'(((64'd1 << DivShift)
                                      + 64'(SECTORS_PER_CLUSTER) - 64'd1)
                                      / 64'(SECTORS_PER_CLUSTER));

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WRITE,
    S_FILL,
    S_WALK,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     used_q, used_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;
  res_t                res_q, res_d;
  cmd_t                cmd_q, cmd_d;
  logic [CntW-1:0]     lim_q, lim_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic                vld_q, vld_d;
  logic [IdxW-1:0]     vidx_q, vidx_d;
  logic [SEC_W-1:0]    num_q, num_d;
  logic [SEC_W-1:0]    quo_q, quo_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [FAT_W-1:0]    c_q, c_d;
  logic [SEC_W-1:0]    start_q, start_d;
  logic                hit_q, hit_d;

  logic                we;
  logic [IdxW-1:0]     waddr;
  logic [WORD_W-1:0]   wdata, rdata;

  logic [CntW-1:0]     slot_lim, walk_lim;
  logic [CntW:0]       meta_sum;
  logic [SEC_W-1:0]    numer;
  logic [ProdW-1:0]    prod;
  logic                issue;
  logic [FAT_W-1:0]    ncl, last, tgt16;
  logic [SEC_W-1:0]    len;
  logic [FAT_W:0]      csum;
  logic [SEC_W+1:0]    endp;

  vfcm_ram #(
    .Width (WORD_W),
    .Depth (MAX_ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign slot_lim = (LimW'(table_entries_i) < LimW'(MAX_ENTRIES)) ?
                    CntW'(table_entries_i) : CntW'(MAX_ENTRIES);
  assign walk_lim = (used_q < slot_lim) ? used_q : slot_lim;
  assign meta_sum = (CntW+1)'(used_q) + (CntW+1)'(cmd_i.slot_count);
  assign numer    = cmd_i.sectors + SEC_W'(SECTORS_PER_CLUSTER - 1);
  assign prod     = ProdW'(num_q) * ProdW'(RecipM);
  assign issue    = (rd_q < lim_q);
  assign ncl      = rdata[WORD_W-1:SEC_W];
  assign len      = rdata[SEC_W-1:0];
  assign csum     = {1'b0, c_q} + {1'b0, ncl};
  assign last     = csum[FAT_W-1:0];
  assign tgt16    = cmd_q.target[FAT_W-1:0];
  assign endp     = {2'b00, start_q} + {2'b00, len};

  assign waddr       = used_q[IdxW-1:0];
  assign busy_o      = (state_q != S_IDLE);
  assign used_o      = used_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    out_valid_d = out_valid_q & ~res_take_i;
    out_d       = out_q;
    res_d       = res_q;
    cmd_d       = cmd_q;
    lim_d       = lim_q;
    rd_d        = rd_q;
    vld_d       = 1'b0;
    vidx_d      = vidx_q;
    num_d       = num_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    c_d         = c_q;
    start_d     = start_q;
    hit_d       = hit_q;
    cmd_take_o  = 1'b0;
    we          = 1'b0;
    wdata       = '0;

    unique case (state_q)
      S_IDLE: begin
        res_d = '0;
        rd_d  = '0;
        lim_d = walk_lim;
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          cmd_d      = cmd_i;
          unique case (cmd_i.op)
            OP_CLEAR: begin
              used_d  = '0;
              state_d = S_DONE;
            end
            OP_ADD_FILE: begin
              if (used_q >= slot_lim) begin
                res_d.status = 1'b1;
                state_d      = S_DONE;
              end else begin
                num_d   = numer;
                state_d = S_DIV;
              end
            end
            OP_ADD_META: begin
              if (cmd_i.slot_count == '0) begin
                state_d = S_DONE;
              end else if (meta_sum > (CntW+1)'(slot_lim)) begin
                res_d.status = 1'b1;
                state_d      = S_DONE;
              end else begin
                cnt_d   = cmd_i.slot_count;
                state_d = S_FILL;
              end
            end
            OP_FAT: begin
              if (cmd_i.target[FAT_W-1:0] == 16'd0) begin
                res_d.fat_entry = FAT_ENTRY0;
                state_d         = S_DONE;
              end else if (cmd_i.target[FAT_W-1:0] == 16'd1) begin
                res_d.fat_entry = FAT_EOC;
                state_d         = S_DONE;
              end else begin
                c_d     = FIRST_CLUST;
                state_d = S_WALK;
              end
            end
            OP_MAP: begin
              start_d = '0;
              hit_d   = 1'b0;
              state_d = S_WALK;
            end
            OP_NOP: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        quo_d   = prod[DivShift +: SEC_W];
        state_d = S_WRITE;
      end
      S_WRITE: begin
        we               = 1'b1;
        wdata            = {quo_q[FAT_W-1:0], quo_q * SEC_W'(SECTORS_PER_CLUSTER)};
        res_d.file_index = INDEX_W'(used_q);
        used_d           = used_q + CntW'(1);
        state_d          = S_DONE;
      end
      S_FILL: begin
        we     = 1'b1;
        used_d = used_q + CntW'(1);
        cnt_d  = cnt_q - COUNT_W'(1);
        if (cnt_q == COUNT_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        vld_d  = issue;
        vidx_d = rd_q[IdxW-1:0];
        if (issue) begin
          rd_d = rd_q + CntW'(1);
        end
        if (vld_q && len != '0) begin
          if (cmd_q.op == OP_FAT) begin
            if (last >= c_q) begin
              if (tgt16 >= c_q && tgt16 < last) begin
                res_d.fat_entry = (({1'b0, tgt16} + 17'd1) < {1'b0, last}) ?
                                  tgt16 + 16'd1 : FAT_EOC;
              end
              c_d = last;
            end
          end else if (!hit_q) begin
            if ({2'b00, cmd_q.target} < endp) begin
              hit_d                = 1'b1;
              res_d.hit            = 1'b1;
              res_d.file_index     = INDEX_W'(vidx_q);
              res_d.sector_in_file = SECOFS_W'(cmd_q.target - start_q);
            end else begin
              start_d = endp[SEC_W-1:0];
            end
          end
        end
        if (!issue && !vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || res_take_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      vld_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    res_q   <= res_d;
    cmd_q   <= cmd_d;
    lim_q   <= lim_d;
    rd_q    <= rd_d;
    vidx_q  <= vidx_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    c_q     <= c_d;
    start_q <= start_d;
    hit_q   <= hit_d;
  end

endmodule

// ----- rtl/core/virtual_fat16_cluster_mapper.sv -----
// Top level of the virtual FAT16 cluster mapper: queue ports, config register, checks.
//
// Requests enter a two-entry command queue and are carried out one at a time by the
// back end; each produces exactly one result, held in an output register until popped.
// Clear, unknown requests, refused adds and reads of FAT entries 0 and 1 go from
// idle straight to the done state in the back end. Adding a file passes through a
// reciprocal multiplication that turns the sector count into whole clusters, then a
// slot table write. Reserving N non-data slots makes N slot table writes, one per
// cycle. FAT reads and sector lookups walk the slot table through the read port of
// its RAM, one slot per cycle, over min(used slots, table_entries, MAX_ENTRIES)
// slots. No clearing pass runs after reset: slots are only read below the fill
// count, and every such slot has been written.
module virtual_fat16_cluster_mapper #(
  parameter int MAX_ENTRIES         = 64,
  parameter int SECTORS_PER_CLUSTER = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [2:0]                     req_type_i,
  input  logic [vfcm_pkg::SIZE_W-1:0]    file_size_i,
  input  logic [vfcm_pkg::COUNT_W-1:0]   slot_count_i,
  input  logic [vfcm_pkg::TARGET_W-1:0]  target_index_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           status_o,
  output logic [vfcm_pkg::FAT_W-1:0]     fat_entry_o,
  output logic                           hit_o,
  output logic [vfcm_pkg::INDEX_W-1:0]   file_index_o,
  output logic [vfcm_pkg::SECOFS_W-1:0]  sector_in_file_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vfcm_pkg::CFG_W-1:0]     cfg_table_entries_i
);
  import vfcm_pkg::*;

  localparam int CntW = $clog2(MAX_ENTRIES + 1);

  logic             cmd_valid, cmd_take;
  cmd_t             cmd;
  res_t             res;
  logic             res_valid, res_take;
  logic             busy;
  logic [CntW-1:0]  used;
  logic [CFG_W-1:0] table_entries_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_entries_q <= TABLE_ENTRIES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_entries_q <= cfg_table_entries_i;
    end
  end

  vfcm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .req_type_i     (req_type_i),
    .file_size_i    (file_size_i),
    .slot_count_i   (slot_count_i),
    .target_index_i (target_index_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_take_i     (cmd_take)
  );

  vfcm_back #(
    .MAX_ENTRIES         (MAX_ENTRIES),
    .SECTORS_PER_CLUSTER (SECTORS_PER_CLUSTER)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_take_o      (cmd_take),
    .table_entries_i (table_entries_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_take_i      (res_take),
    .busy_o          (busy),
    .used_o          (used)
  );

  assign empty            = ~res_valid;
  assign res_take         = pop & ~empty;
  assign status_o         = res.status;
  assign fat_entry_o      = res.fat_entry;
  assign hit_o            = res.hit;
  assign file_index_o     = res.file_index;
  assign sector_in_file_o = res.sector_in_file;

  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= CntW'(MAX_ENTRIES))
    else $error("slot fill count above table size");

  // a new result only appears when the back end was working on a transaction
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(busy))
    else $error("result appeared without a transaction in progress");

  // a waiting result is never dropped before it is popped
  a_res_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !pop) |=> res_valid)
    else $error("waiting result lost");

endmodule
